[rtl/greedy_nearest_point_matcher_macros.svh]
// Assertion macros for the greedy nearest point matcher.
`ifndef GREEDY_NEAREST_POINT_MATCHER_MACROS_SVH
`define GREEDY_NEAREST_POINT_MATCHER_MACROS_SVH
`ifndef SYNTH
`define GNPM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GNPM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GNPM_ASSERT_IMP(label, ante, cons, msg)
`define GNPM_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[rtl/gnpm_pkg.sv]
// Shared types and constants of the greedy nearest point matcher.
`default_nettype none
package gnpm_pkg;
    localparam int COORD_W = 16;
    localparam int POINT_W = 3 * COORD_W;
    localparam int TAG_W   = 6;
    localparam int SQ_W    = 33;
    localparam int SUM_W   = 36;
    localparam int DIST_W  = 18;
    localparam int ISQRT_STEPS = 18;

    typedef struct packed {
        logic [POINT_W-1:0] point;
        logic [TAG_W-1:0]   tag;
        logic               unused;
    } cand_cell_t;

    typedef struct packed {
        logic             shift;
        logic             clr_all;
        logic             clr_en;
        logic [TAG_W-1:0] clr_tag;
    } cell_ctl_t;
endpackage
`default_nettype wire

[rtl/gnpm_ram.sv]
// Generic single write port RAM with registered read.
`default_nettype none
module gnpm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/gnpm_cell.sv]
// One candidate cell of the rotating candidate chain.
`default_nettype none
module gnpm_cell
    import gnpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctl_t  ctl,
    input  wire cand_cell_t neighbor,
    output cand_cell_t      slot
);
    cand_cell_t cell_reg;
    cand_cell_t cell_next;

    always_comb
    begin
        cell_next = cell_reg;
        if (ctl.clr_all)
        begin
            cell_next.unused = 1'b0;
        end
        else if (ctl.shift)
        begin
            cell_next = neighbor;
        end
        else if (ctl.clr_en && (cell_reg.tag == ctl.clr_tag))
        begin
            cell_next.unused = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign slot = cell_reg;
endmodule
`default_nettype wire

[rtl/gnpm_dist.sv]
// Distance unit: squared difference sum and bitwise integer square root.
`default_nettype none
module gnpm_dist
    import gnpm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [POINT_W-1:0] pa,
    input  wire logic [POINT_W-1:0] pb,
    output logic                    done,
    output logic      [DIST_W-1:0]  dist_val
);
    localparam logic [SUM_W-1:0] BIT_INIT = SUM_W'(1) << (SUM_W - 2);
    localparam int STEP_W = $clog2(ISQRT_STEPS + 2);
    localparam logic [STEP_W-1:0] STEP_SUM  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ISQRT_STEPS + 1);

    logic [SQ_W-1:0]   sq_reg [3];
    logic [SUM_W-1:0]  v_reg;
    logic [SUM_W-1:0]  res_reg;
    logic [SUM_W-1:0]  bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic signed [16:0] diff [3];
    logic signed [33:0] prod [3];
    logic [SUM_W-1:0]  trial;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = $signed({pa[k*COORD_W+COORD_W-1], pa[k*COORD_W +: COORD_W]})
                    - $signed({pb[k*COORD_W+COORD_W-1], pb[k*COORD_W +: COORD_W]});
            prod[k] = diff[k] * diff[k];
        end
    end

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_SUM;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= prod[k][SQ_W-1:0];
            end
        end
        else if (busy_reg && (step_reg == STEP_SUM))
        begin
            v_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            res_reg <= '0;
            bit_reg <= BIT_INIT;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done     = done_reg;
    assign dist_val = res_reg[DIST_W-1:0];
endmodule
`default_nettype wire

[rtl/greedy_nearest_point_matcher.sv]
// Greedy nearest point matcher: loads two point sets, then pairs them greedily.
// Loading takes one cycle per item; the input is closed while a run is active.
// Each reference point costs a scan of the chain plus output stalls: the chain rotates one
// cell per cycle while no distance is being computed, the distance unit runs (sum, 18 root
// steps, done) per unused candidate, and a run ends with a clear state.
// Reset empties both sets and clears all candidate flags; no clearing pass is needed.
`default_nettype none
`include "greedy_nearest_point_matcher_macros.svh"
module greedy_nearest_point_matcher
    import gnpm_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // coord_x, coord_y, coord_z
    input  wire logic        s_tuser,  // cloud_select
    input  wire logic        s_tlast,  // load_done
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [95:0] m_tdata,  // match_x, match_y, match_z, ref_x, ref_y, ref_z
    output logic             m_tuser,  // match_found
    output logic             m_tlast   // final_pair
);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(MAX_POINTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_SCAN, S_DIST, S_FIN, S_EMIT, S_CLEAR
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   ref_cnt_reg;
    logic [CNT_W-1:0]   cand_cnt_reg;
    logic [CNT_W-1:0]   ri_reg;
    logic [CNT_W-1:0]   rot_reg;
    logic               found_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [TAG_W-1:0]   best_tag_reg;
    logic [POINT_W-1:0] best_pt_reg;
    logic               out_valid_reg;
    logic [95:0]        out_data_reg;
    logic               out_found_reg;
    logic               out_last_reg;

    cand_cell_t         cells [MAX_POINTS];
    cand_cell_t         tail_in;
    cell_ctl_t          ctl;
    logic               in_acc;
    logic               out_acc;
    logic               ref_we;
    logic               cand_ld;
    logic [POINT_W-1:0] ref_pt;
    logic               dist_start;
    logic               dist_done;
    logic [DIST_W-1:0]  dist_val;
    logic               rot_now;
    logic               better;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign ref_we  = in_acc && !s_tuser && (ref_cnt_reg < CNT_MAX);
    assign cand_ld = in_acc && s_tuser && (cand_cnt_reg < CNT_MAX);

    gnpm_ram #(
        .WIDTH(POINT_W),
        .DEPTH(MAX_POINTS)
    ) u_ref_ram (
        .clk  (clk),
        .we   (ref_we),
        .waddr(ref_cnt_reg[ADDR_W-1:0]),
        .wdata(s_tdata),
        .raddr(ri_reg[ADDR_W-1:0]),
        .rdata(ref_pt)
    );

    // Rotate in the scan states, append at the tail on a candidate load.
    assign rot_now = ((state_reg == S_SCAN) && !cells[0].unused) ||
                     ((state_reg == S_DIST) && dist_done);
    assign better  = !found_reg || (dist_val < best_reg);

    always_comb
    begin
        if (cand_ld)
        begin
            tail_in.point  = s_tdata;
            tail_in.tag    = TAG_W'(cand_cnt_reg);
            tail_in.unused = 1'b1;
        end
        else
        begin
            tail_in = cells[0];
        end
        ctl.shift   = cand_ld || rot_now;
        ctl.clr_all = (state_reg == S_CLEAR);
        ctl.clr_en  = (state_reg == S_FIN) && found_reg;
        ctl.clr_tag = best_tag_reg;
    end

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        gnpm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .neighbor((i == MAX_POINTS - 1) ? tail_in : cells[(i + 1) % MAX_POINTS]),
            .slot    (cells[i])
        );
    end

    assign dist_start = (state_reg == S_SCAN) && cells[0].unused;

    gnpm_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (dist_start),
        .pa      (ref_pt),
        .pb      (cells[0].point),
        .done    (dist_done),
        .dist_val(dist_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ref_cnt_reg   <= '0;
            cand_cnt_reg  <= '0;
            ri_reg        <= '0;
            rot_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (ref_we)
                        begin
                            ref_cnt_reg <= ref_cnt_reg + 1'b1;
                        end
                        if (cand_ld)
                        begin
                            cand_cnt_reg <= cand_cnt_reg + 1'b1;
                        end
                        if (s_tlast)
                        begin
                            ri_reg <= '0;
                            if ((ref_cnt_reg == '0) && !ref_we)
                            begin
                                state_reg <= S_CLEAR;
                            end
                            else
                            begin
                                state_reg <= S_READ;
                            end
                        end
                    end
                end
                S_READ:
                begin
                    rot_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (cells[0].unused)
                    begin
                        state_reg <= S_DIST;
                    end
                    else
                    begin
                        rot_reg   <= rot_reg + 1'b1;
                        state_reg <= (rot_reg == ROT_LAST) ? S_FIN : S_SCAN;
                    end
                end
                S_DIST:
                begin
                    if (dist_done)
                    begin
                        if (better)
                        begin
                            found_reg    <= 1'b1;
                            best_reg     <= dist_val;
                            best_tag_reg <= cells[0].tag;
                            best_pt_reg  <= cells[0].point;
                        end
                        rot_reg   <= rot_reg + 1'b1;
                        state_reg <= (rot_reg == ROT_LAST) ? S_FIN : S_SCAN;
                    end
                end
                S_FIN:
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= {found_reg ? best_pt_reg : {POINT_W{1'b0}}, ref_pt};
                    out_found_reg <= found_reg;
                    out_last_reg  <= (CNT_W'(ri_reg + 1'b1) == ref_cnt_reg);
                    state_reg     <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_acc)
                    begin
                        out_valid_reg <= 1'b0;
                        ri_reg        <= ri_reg + 1'b1;
                        state_reg     <= out_last_reg ? S_CLEAR : S_READ;
                    end
                end
                S_CLEAR:
                begin
                    ref_cnt_reg  <= '0;
                    cand_cnt_reg <= '0;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

    `GNPM_ASSERT_IMP(a_no_overlap, s_tready, !m_tvalid, "input open while a result waits")
    `GNPM_ASSERT_IMP(a_done_in_dist, dist_done, state_reg == S_DIST, "distance done outside wait")
    `GNPM_ASSERT_NXT(a_last_clears, out_acc && m_tlast, state_reg == S_CLEAR, "run end not cleared")
    `GNPM_ASSERT_IMP(a_none_zero, m_tvalid && !m_tuser, m_tdata[95:48] == '0, "no match but nonzero")
endmodule
`default_nettype wire
